[rtl/aid_pkg.sv]
package aid_pkg;

    typedef enum logic [4:0] {
        CLS_UNSUP   = 5'd0,  CLS_SVC     = 5'd1,  CLS_HINT    = 5'd2,  CLS_ADR     = 5'd3,
        CLS_ADDI    = 5'd4,  CLS_ADDSR   = 5'd5,  CLS_ADDER   = 5'd6,  CLS_BIMM    = 5'd7,
        CLS_BREG    = 5'd8,  CLS_CBZ     = 5'd9,  CLS_TBZ     = 5'd10, CLS_BCOND   = 5'd11,
        CLS_CCMP    = 5'd12, CLS_CSEL    = 5'd13, CLS_LSPAIR  = 5'd14, CLS_LSUIMM  = 5'd15,
        CLS_LSSIMM  = 5'd16, CLS_LSREG   = 5'd17, CLS_LOGSR   = 5'd18, CLS_LOGI    = 5'd19,
        CLS_BFM     = 5'd20, CLS_EXTR    = 5'd21, CLS_DP1     = 5'd22, CLS_DP2     = 5'd23,
        CLS_MUL     = 5'd24, CLS_MOVW    = 5'd25, CLS_CLREX   = 5'd26, CLS_LSEX    = 5'd27,
        CLS_SYSREG  = 5'd28
    } t_class;

    localparam int unsigned F_64   = 0;
    localparam int unsigned F_SUB  = 1;
    localparam int unsigned F_SET  = 2;
    localparam int unsigned F_LINK = 3;
    localparam int unsigned F_PAGE = 4;
    localparam int unsigned F_NZ   = 5;
    localparam int unsigned F_LOAD = 6;
    localparam int unsigned F_SEXT = 7;
    localparam int unsigned F_EXCL = 8;
    localparam int unsigned F_ACQ  = 9;
    localparam int unsigned F_REL  = 10;
    localparam int unsigned F_IMM  = 11;
    localparam int unsigned F_INV  = 12;
    localparam int unsigned F_SYSW = 13;

    localparam logic [1:0] M_POST = 2'd0;
    localparam logic [1:0] M_OFF  = 2'd1;
    localparam logic [1:0] M_PRE  = 2'd2;

    typedef struct packed {
        t_class      cls;
        logic [4:0]  rd;
        logic [4:0]  rn;
        logic [4:0]  rm;
        logic [4:0]  rx;
        logic [63:0] imm;
        logic [3:0]  sub_op;
        logic [5:0]  amount;
        logic [5:0]  aux;
        logic [1:0]  mode;
        logic [13:0] flags;
        logic [3:0]  sizes;
    } t_record;

endpackage

[rtl/aid_bitmask.sv]
module aid_bitmask (
    input  logic        i_is64,
    input  logic        i_n,
    input  logic [5:0]  i_immr,
    input  logic [5:0]  i_imms,
    output logic        o_ok,
    output logic [63:0] o_mask
);
    logic [6:0]  src;
    logic [2:0]  len;
    logic [5:0]  levels;
    logic [5:0]  s;
    logic [5:0]  r;
    logic [63:0] el;
    logic [63:0] rot;
    logic [63:0] acc;
    logic [6:0]  esize;

    always_comb begin
        src = {i_n, ~i_imms};
        len = 3'd0;
        for (int k = 1; k < 7; k++) begin
            if (src[k]) len = 3'(k);
        end
        levels = 6'((7'd1 << len) - 7'd1);
        esize  = 7'd1 << len;
        s      = i_imms & levels;
        r      = i_immr & levels;
        o_ok   = (src != 7'd0) && !(!i_is64 && len == 3'd6) && (s != levels);
        el     = 64'((65'd1 << (7'(s) + 7'd1)) - 65'd1);
        // Rotate right within the element, then replicate across the register.
        rot = el;
        if (r != 6'd0) begin
            rot = (el >> r) | (el << (esize - 7'(r)));
        end
        if (esize != 7'd64) begin
            rot = rot & ((64'd1 << esize[5:0]) - 64'd1);
        end
        acc = 64'd0;
        for (int k = 0; k < 64; k++) begin
            acc[k] = rot[k % 64 & int'(levels)];
        end
        if (!i_is64) acc[63:32] = 32'd0;
        o_mask = acc;
    end
endmodule

[rtl/aid_decode.sv]
module aid_decode (
    input  logic [31:0]      i_word,
    output aid_pkg::t_record o_rec
);
    import aid_pkg::*;

    logic        ok_bm;
    logic [63:0] bm;
    t_record     d;
    logic [4:0]  rd, rn, rm;
    logic        sf;
    logic [31:0] w;
    logic [1:0]  lsz, lopc;
    logic        ls_ok;
    logic        ls_load, ls_sext;
    logic [1:0]  ls_res;
    logic [31:0] p;
    logic [2:0]  fam;
    logic [1:0]  sc;
    logic [15:0] sr;
    logic [5:0]  f6;

    assign w  = i_word;
    assign rd = w[4:0];
    assign rn = w[9:5];
    assign rm = w[20:16];
    assign sf = w[31];

    aid_bitmask u_bm (
        .i_is64 (sf),
        .i_n    (w[22]),
        .i_immr (w[21:16]),
        .i_imms (w[15:10]),
        .o_ok   (ok_bm),
        .o_mask (bm)
    );

    // Shared load/store size and sign-extension decode.
    always_comb begin
        lsz     = w[31:30];
        lopc    = w[23:22];
        ls_ok   = 1'b1;
        ls_load = lopc != 2'd0;
        ls_sext = 1'b0;
        ls_res  = lsz;
        if (lopc == 2'd2) begin
            ls_ok = lsz != 2'd3; ls_sext = 1'b1; ls_res = 2'd2;
        end else if (lopc == 2'd3) begin
            ls_ok = !lsz[1]; ls_sext = 1'b1; ls_res = 2'd3;
        end
    end

    always_comb begin
        d   = '0;
        p   = w & 32'hfffffc1f;
        fam = w[23:21];
        sc  = w[31] ? 2'd3 : 2'd2;
        sr  = w[20:5];
        f6  = w[15:10];
        if ((w & 32'hffe0001f) == 32'hd4000001) begin
            d.cls = CLS_SVC;
        end else if ((w & 32'hfffff01f) == 32'hd503201f) begin
            d.cls = CLS_HINT;
        end else if ((w & 32'h1f000000) == 32'h10000000) begin
            d.cls = CLS_ADR; d.rd = rd;
            d.imm = {{43{w[23]}}, w[23:5], w[30:29]};
            if (sf) begin
                d.flags[F_PAGE] = 1'b1; d.imm = d.imm << 12;
            end
        end else if ((w & 32'h1f000000) == 32'h11000000) begin
            if (!w[23]) begin
                d.cls = CLS_ADDI; d.rd = rd; d.rn = rn; d.imm = 64'(w[21:10]);
                d.mode = w[23:22]; d.flags[2:0] = {w[29], w[30], sf};
            end
        end else if ((w & 32'h1f200000) == 32'h0b000000) begin
            if (!(w[23:22] == 2'd3 || (!sf && w[15]))) begin
                d.cls = CLS_ADDSR; d.rd = rd; d.rn = rn; d.rm = rm; d.mode = w[23:22];
                d.amount = w[15:10]; d.flags[2:0] = {w[29], w[30], sf};
            end
        end else if ((w & 32'h1f200000) == 32'h0b200000) begin
            if (w[12:10] <= 3'd4) begin
                d.cls = CLS_ADDER; d.rd = rd; d.rn = rn; d.rm = rm;
                d.amount = 6'(w[12:10]); d.aux = 6'(w[15:13]);
                d.flags[2:0] = {w[29], w[30], sf};
            end
        end else if ((w & 32'h7c000000) == 32'h14000000) begin
            d.cls = CLS_BIMM; d.imm = {{36{w[25]}}, w[25:0], 2'b00};
            d.flags[F_LINK] = sf;
        end else if (p == 32'hd61f0000 || p == 32'hd63f0000 || p == 32'hd65f0000) begin
            d.cls = CLS_BREG; d.rn = rn;
            d.sub_op = (p == 32'hd61f0000) ? 4'd0 : (p == 32'hd63f0000) ? 4'd1 : 4'd2;
            d.flags[F_LINK] = p == 32'hd63f0000;
        end else if ((w & 32'h7e000000) == 32'h34000000) begin
            d.cls = CLS_CBZ; d.rd = rd; d.imm = {{43{w[23]}}, w[23:5], 2'b00};
            d.flags[F_64] = sf; d.flags[F_NZ] = w[24];
        end else if ((w & 32'h7e000000) == 32'h36000000) begin
            d.cls = CLS_TBZ; d.rd = rd; d.imm = {{48{w[18]}}, w[18:5], 2'b00};
            d.amount = {w[31], w[23:19]}; d.flags[F_NZ] = w[24];
        end else if ((w & 32'hff000010) == 32'h54000000) begin
            d.cls = CLS_BCOND; d.aux = 6'(w[3:0]);
            d.imm = {{43{w[23]}}, w[23:5], 2'b00};
        end else if ((w & 32'h1fe00000) == 32'h1a400000) begin
            d.cls = CLS_CCMP; d.rn = rn; d.rm = rm; d.imm = 64'(rm);
            d.aux = 6'(w[15:12]); d.sub_op = w[3:0];
            d.flags[F_64] = sf; d.flags[F_SUB] = w[30]; d.flags[F_IMM] = w[11];
        end else if ((w & 32'h1fe00000) == 32'h1a800000) begin
            d.cls = CLS_CSEL; d.rd = rd; d.rn = rn; d.rm = rm; d.aux = 6'(w[15:12]);
            d.sub_op = {2'b00, w[30], w[10]}; d.flags[F_64] = sf;
        end else if ((w & 32'h3a000000) == 32'h28000000) begin
            if (!(w[24:23] == 2'd0 || w[30])) begin
                d.cls = CLS_LSPAIR; d.rd = rd; d.rn = rn; d.rx = w[14:10];
                d.flags[F_LOAD] = w[22]; d.sizes = {sc, sc};
                d.imm = {{57{w[21]}}, w[21:15]} << sc;
                d.mode = (w[24:23] == 2'd1) ? M_POST : (w[24:23] == 2'd2) ? M_OFF : M_PRE;
            end
        end else if ((w & 32'h3b000000) == 32'h39000000) begin
            if (ls_ok) begin
                d.cls = CLS_LSUIMM; d.rd = rd; d.rn = rn;
                d.flags[F_LOAD] = ls_load; d.flags[F_SEXT] = ls_sext;
                d.sizes = {ls_res, lsz}; d.imm = 64'(w[21:10]) << lsz; d.mode = M_OFF;
            end
        end else if ((w & 32'h3b200000) == 32'h38000000) begin
            if (w[11:10] != 2'd2 && ls_ok) begin
                d.cls = CLS_LSSIMM; d.rd = rd; d.rn = rn;
                d.flags[F_LOAD] = ls_load; d.flags[F_SEXT] = ls_sext;
                d.sizes = {ls_res, lsz}; d.imm = {{55{w[20]}}, w[20:12]};
                d.mode = (w[11:10] == 2'd0) ? M_OFF : (w[11:10] == 2'd1) ? M_POST : M_PRE;
            end
        end else if ((w & 32'h3b200c00) == 32'h38200800) begin
            if (w[14] && ls_ok) begin
                d.cls = CLS_LSREG; d.rd = rd; d.rn = rn; d.rm = rm;
                d.flags[F_LOAD] = ls_load; d.flags[F_SEXT] = ls_sext;
                d.sizes = {ls_res, lsz}; d.aux = 6'(w[15:13]);
                d.amount = 6'(w[12]); d.mode = M_OFF;
            end
        end else if ((w & 32'h1f000000) == 32'h0a000000) begin
            if (!(!sf && w[15])) begin
                d.cls = CLS_LOGSR; d.rd = rd; d.rn = rn; d.rm = rm; d.mode = w[23:22];
                d.amount = w[15:10];
                d.sub_op = (w[30:29] == 2'd3) ? 4'd0 : 4'(w[30:29]);
                d.flags[F_64] = sf; d.flags[F_INV] = w[21];
                d.flags[F_SET] = w[30:29] == 2'd3;
            end
        end else if ((w & 32'h1f800000) == 32'h12000000) begin
            if (ok_bm) begin
                d.cls = CLS_LOGI; d.rd = rd; d.rn = rn; d.imm = bm;
                d.sub_op = (w[30:29] == 2'd3) ? 4'd0 : 4'(w[30:29]);
                d.flags[F_64] = sf; d.flags[F_SET] = w[30:29] == 2'd3;
            end
        end else if ((w & 32'h1f800000) == 32'h13000000) begin
            if (w[30:29] != 2'd3 && !(!sf && (w[22] || w[21] || w[15])) && !(sf && !w[22]))
            begin
                d.cls = CLS_BFM; d.rd = rd; d.rn = rn; d.amount = w[21:16];
                d.aux = w[15:10]; d.sub_op = 4'(w[30:29]); d.flags[F_64] = sf;
            end
        end else if ((w & 32'h7f800000) == 32'h13800000) begin
            if (w[22] == sf && !(!sf && w[15])) begin
                d.cls = CLS_EXTR; d.rd = rd; d.rn = rn; d.rm = rm;
                d.amount = w[15:10]; d.flags[F_64] = sf;
            end
        end else if ((w & 32'h5fe00000) == 32'h5ac00000) begin
            if (f6 == 6'd4) begin
                d.cls = CLS_DP1; d.rd = rd; d.rn = rn; d.flags[F_64] = sf;
            end
        end else if ((w & 32'h7fe00000) == 32'h1ac00000) begin
            if (f6 == 6'd2 || f6 == 6'd3 || (f6 >= 6'd8 && f6 <= 6'd11)) begin
                d.cls = CLS_DP2; d.rd = rd; d.rn = rn; d.rm = rm; d.flags[F_64] = sf;
                d.sub_op = (f6 <= 6'd3) ? 4'(f6 - 6'd2) : 4'(f6 - 6'd6);
            end
        end else if ((w & 32'h7f000000) == 32'h1b000000) begin
            d.cls = CLS_MUL; d.rd = rd; d.rn = rn; d.rx = w[14:10]; d.rm = rm;
            d.flags[F_64] = sf;
            if (fam == 3'd0) d.sub_op = 4'(w[15]);
            else if (fam == 3'd1 && sf) d.sub_op = 4'd2 + 4'(w[15]);
            else if (fam == 3'd2 && sf && !w[15] && w[14:10] == 5'd31) d.sub_op = 4'd4;
            else if (fam == 3'd5 && sf) d.sub_op = 4'd5 + 4'(w[15]);
            else if (fam == 3'd6 && sf && !w[15] && w[14:10] == 5'd31) d.sub_op = 4'd7;
            else d = '0;
        end else if ((w & 32'h1f800000) == 32'h12800000) begin
            if (w[30:29] != 2'd1 && !(!sf && w[22])) begin
                d.cls = CLS_MOVW; d.rd = rd; d.imm = 64'(w[20:5]);
                d.amount = {w[22:21], 4'd0};
                d.sub_op = (w[30:29] == 2'd0) ? 4'd0 : (w[30:29] == 2'd2) ? 4'd1 : 4'd2;
                d.flags[F_64] = sf;
            end
        end else if (w == 32'hd5033f5f) begin
            d.cls = CLS_CLREX;
        end else if ((w & 32'h3f007c00) == 32'h08007c00) begin
            if (!((!w[22] && w[23] && rm != 5'd31) || (w[22] && rm != 5'd31))) begin
                d.cls = CLS_LSEX; d.rd = rd; d.rn = rn; d.rx = rm;
                d.sizes = {w[31:30], w[31:30]};
                d.flags[F_LOAD] = w[22]; d.flags[F_EXCL] = !w[23];
                d.flags[F_ACQ] = w[22] && w[15]; d.flags[F_REL] = !w[22] && w[15];
            end
        end else if ((w & 32'hffd00000) == 32'hd5100000) begin
            if (sr == 16'hde82 || sr == 16'hda10) begin
                d.cls = CLS_SYSREG; d.rd = rd; d.sub_op = (sr == 16'hde82) ? 4'd0 : 4'd1;
                d.flags[F_SYSW] = !w[21];
            end
        end
        if (d.cls == CLS_UNSUP) d = '0;
        o_rec = d;
    end
endmodule

[rtl/aarch64_instruction_decoder_core.sv]
// A64 instruction decoder. One 32-bit instruction word is accepted per cycle and the
// decoded record appears on the output register in the next cycle; throughput is one
// transaction per cycle, set by the single registered decode stage. A full output
// register is replaced in the same cycle it is taken, so the input stalls only when
// the result is held by the consumer.
module aarch64_instruction_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_instruction_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_instr_class,
    output logic [4:0]  o_dest_reg,
    output logic [4:0]  o_src_reg_a,
    output logic [4:0]  o_src_reg_b,
    output logic [4:0]  o_extra_reg,
    output logic signed [63:0] o_immediate,
    output logic [3:0]  o_sub_op,
    output logic [5:0]  o_amount,
    output logic [5:0]  o_aux_field,
    output logic [1:0]  o_mode,
    output logic [13:0] o_flags,
    output logic [3:0]  o_sizes
);
    import aid_pkg::*;

    t_record r_rec;
    t_record n_rec;
    logic    r_valid;

    aid_decode u_dec (
        .i_word (i_instruction_word),
        .o_rec  (n_rec)
    );

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_rec <= n_rec;
        end
    end

    assign o_valid        = r_valid;
    assign o_instr_class  = r_rec.cls;
    assign o_dest_reg     = r_rec.rd;
    assign o_src_reg_a    = r_rec.rn;
    assign o_src_reg_b    = r_rec.rm;
    assign o_extra_reg    = r_rec.rx;
    assign o_immediate    = r_rec.imm;
    assign o_sub_op       = r_rec.sub_op;
    assign o_amount       = r_rec.amount;
    assign o_aux_field    = r_rec.aux;
    assign o_mode         = r_rec.mode;
    assign o_flags        = r_rec.flags;
    assign o_sizes        = r_rec.sizes;
endmodule

[rtl/aid_checker.sv]
module aid_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [4:0]  o_instr_class,
    input logic [63:0] o_immediate,
    input logic [13:0] o_flags
);
    import aid_pkg::*;

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> o_valid)
        else $error("accepted transaction not presented");
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("ready low with empty output");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_immediate))
        else $error("stalled result changed");
    a_unsup_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_instr_class == CLS_UNSUP |-> o_immediate == 64'd0 && o_flags == 14'd0)
        else $error("unsupported record not cleared");
endmodule

bind aarch64_instruction_decoder_core aid_checker u_aid_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_instr_class  (o_instr_class),
    .o_immediate    (o_immediate),
    .o_flags        (o_flags)
);

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import aid_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_instruction_word;
    logic        o_valid;
    logic        i_ready;
    logic [4:0]  o_instr_class;
    logic [4:0]  o_dest_reg;
    logic [4:0]  o_src_reg_a;
    logic [4:0]  o_src_reg_b;
    logic [4:0]  o_extra_reg;
    logic signed [63:0] o_immediate;
    logic [3:0]  o_sub_op;
    logic [5:0]  o_amount;
    logic [5:0]  o_aux_field;
    logic [1:0]  o_mode;
    logic [13:0] o_flags;
    logic [3:0]  o_sizes;

    aarch64_instruction_decoder_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_instruction_word(i_instruction_word),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_instr_class(o_instr_class), .o_dest_reg(o_dest_reg),
        .o_src_reg_a(o_src_reg_a), .o_src_reg_b(o_src_reg_b),
        .o_extra_reg(o_extra_reg), .o_immediate(o_immediate), .o_sub_op(o_sub_op),
        .o_amount(o_amount), .o_aux_field(o_aux_field), .o_mode(o_mode),
        .o_flags(o_flags), .o_sizes(o_sizes)
    );

    localparam int NUM_RANDOM = 1000;
    localparam int QUIET_TAIL = 150;

    logic [31:0] word_queue[$];
    t_record     decoded_queue[$];
    int          error_count;
    int          words_sent;
    int          records_seen;
    int          class_hits[32];
    bit          hold_until_drained;
    int          send_gap;
    int          take_gap;
    bit          quiet_phase;

    // Instruction-class templates: fixed bits and the mask of bits left random.
    logic [31:0] tmpl_val[] = '{
        32'hd4000001, 32'hd503201f, 32'h10000000, 32'h11000000, 32'h0b000000,
        32'h0b200000, 32'h14000000, 32'hd61f0000, 32'hd63f0000, 32'hd65f0000,
        32'h34000000, 32'h36000000, 32'h54000000, 32'h1a400000, 32'h1a800000,
        32'h28000000, 32'h39000000, 32'h38000000, 32'h38200800, 32'h0a000000,
        32'h12000000, 32'h13000000, 32'h13800000, 32'h5ac01000, 32'h1ac00000,
        32'h1b000000, 32'h12800000, 32'hd5033f5f, 32'h08007c00, 32'hd53bd040,
        32'hd51bd040, 32'hd53b4200};
    logic [31:0] tmpl_msk[] = '{
        32'h001fffe0, 32'h00000fe0, 32'hff000000 | 32'h00ffffff, 32'he0ffffff,
        32'he0dfffff, 32'he0dfffff, 32'h83ffffff, 32'h000003e0, 32'h000003e0,
        32'h000003e0, 32'h81ffffff, 32'h81ffffff, 32'h00ffffef, 32'he01fffff,
        32'he01fffff, 32'hc5ffffff, 32'hc4ffffff, 32'hc4dfffff, 32'hc4dff3ff,
        32'he0ffffff, 32'he07fffff, 32'he07fffff, 32'h807fffff, 32'ha01f03ff,
        32'h801fffff, 32'h80ffffff, 32'he07fffff, 32'h00000000, 32'hc0ff83ff,
        32'h0000001f, 32'h0000001f, 32'h0000001f};

    function automatic logic [63:0] sign_ext(logic [63:0] v, int bits);
        logic [63:0] m;
        m = (bits == 64) ? '1 : ((64'd1 << bits) - 1);
        v &= m;
        if (v[bits - 1]) begin
            v |= ~m;
        end
        return v;
    endfunction

    // Load/store size and opcode; returns 0 when the combination is reserved.
    function automatic bit mem_variant(logic [1:0] size, logic [1:0] opc,
                                       inout t_record r);
        logic [1:0] res;
        res = size;
        if (opc != 0) begin
            r.flags[F_LOAD] = 1'b1;
        end
        if (opc == 2) begin
            if (size == 3) return 0;
            r.flags[F_SEXT] = 1'b1;
            res = 2'd2;
        end else if (opc == 3) begin
            if (size >= 2) return 0;
            r.flags[F_SEXT] = 1'b1;
            res = 2'd3;
        end
        r.sizes = {res, size};
        return 1;
    endfunction

    function automatic bit expand_mask(bit is64, bit n, logic [5:0] immr,
                                       logic [5:0] imms, output logic [63:0] pattern);
        logic [6:0]  src;
        logic [63:0] elem;
        logic [63:0] emask;
        int          len;
        int          esize;
        int          levels;
        int          s;
        int          r;
        pattern = '0;
        src = {n, ~imms};
        if (src == 0) return 0;
        len = 0;
        while ((src >> (len + 1)) != 0) len++;
        if (!is64 && len == 6) return 0;
        levels = (1 << len) - 1;
        if ((imms & levels) == levels) return 0;
        esize = 1 << len;
        s = imms & levels;
        r = immr & levels;
        emask = (esize == 64) ? '1 : ((64'd1 << esize) - 1);
        elem = (64'd1 << (s + 1)) - 1;
        if (r != 0) begin
            elem = ((elem >> r) | (elem << (esize - r))) & emask;
        end
        for (int off = 0; off < (is64 ? 64 : 32); off += esize) begin
            pattern |= elem << off;
        end
        return 1;
    endfunction

    function automatic t_record decode_word(logic [31:0] w);
        t_record     r;
        logic [4:0]  rd;
        logic [4:0]  rn;
        logic [4:0]  rm;
        bit          sf;
        logic [63:0] m;
        logic [31:0] p;
        int          sc;
        int          op;
        logic [15:0] sr;
        r = '0;
        rd = w[4:0];
        rn = w[9:5];
        rm = w[20:16];
        sf = w[31];
        if ((w & 32'hffe0001f) == 32'hd4000001) begin
            r.cls = CLS_SVC;
        end else if ((w & 32'hfffff01f) == 32'hd503201f) begin
            r.cls = CLS_HINT;
        end else if ((w & 32'h1f000000) == 32'h10000000) begin
            r.imm = sign_ext(64'({w[23:5], w[30:29]}), 21);
            r.rd = rd;
            if (sf) begin
                r.flags[F_PAGE] = 1'b1;
                r.imm = r.imm << 12;
            end
            r.cls = CLS_ADR;
        end else if ((w & 32'h1f000000) == 32'h11000000) begin
            if (w[23:22] <= 1) begin
                r.rd = rd; r.rn = rn; r.imm = 64'(w[21:10]); r.mode = w[23:22];
                r.flags[2:0] = {w[29], w[30], sf};
                r.cls = CLS_ADDI;
            end
        end else if ((w & 32'h1f200000) == 32'h0b000000) begin
            if (!(w[23:22] == 3 || (!sf && w[15]))) begin
                r.rd = rd; r.rn = rn; r.rm = rm; r.mode = w[23:22]; r.amount = w[15:10];
                r.flags[2:0] = {w[29], w[30], sf};
                r.cls = CLS_ADDSR;
            end
        end else if ((w & 32'h1f200000) == 32'h0b200000) begin
            if (w[12:10] <= 4) begin
                r.rd = rd; r.rn = rn; r.rm = rm;
                r.amount = 6'(w[12:10]); r.aux = 6'(w[15:13]);
                r.flags[2:0] = {w[29], w[30], sf};
                r.cls = CLS_ADDER;
            end
        end else if ((w & 32'h7c000000) == 32'h14000000) begin
            r.imm = sign_ext(64'(w[25:0]), 26) << 2;
            r.flags[F_LINK] = sf;
            r.cls = CLS_BIMM;
        end else if ((w & 32'hfffffc1f) inside {32'hd61f0000, 32'hd63f0000, 32'hd65f0000}) begin
            p = w & 32'hfffffc1f;
            r.rn = rn;
            r.sub_op = (p == 32'hd61f0000) ? 4'd0 : (p == 32'hd63f0000) ? 4'd1 : 4'd2;
            r.flags[F_LINK] = (p == 32'hd63f0000);
            r.cls = CLS_BREG;
        end else if ((w & 32'h7e000000) == 32'h34000000) begin
            r.rd = rd; r.imm = sign_ext(64'(w[23:5]), 19) << 2;
            r.flags[F_64] = sf; r.flags[F_NZ] = w[24];
            r.cls = CLS_CBZ;
        end else if ((w & 32'h7e000000) == 32'h36000000) begin
            r.rd = rd; r.imm = sign_ext(64'(w[18:5]), 14) << 2;
            r.amount = {w[31], w[23:19]};
            r.flags[F_NZ] = w[24];
            r.cls = CLS_TBZ;
        end else if ((w & 32'hff000010) == 32'h54000000) begin
            r.aux = 6'(w[3:0]); r.imm = sign_ext(64'(w[23:5]), 19) << 2;
            r.cls = CLS_BCOND;
        end else if ((w & 32'h1fe00000) == 32'h1a400000) begin
            r.rn = rn; r.rm = rm; r.imm = 64'(rm); r.aux = 6'(w[15:12]); r.sub_op = w[3:0];
            r.flags[F_64] = sf; r.flags[F_SUB] = w[30]; r.flags[F_IMM] = w[11];
            r.cls = CLS_CCMP;
        end else if ((w & 32'h1fe00000) == 32'h1a800000) begin
            r.rd = rd; r.rn = rn; r.rm = rm; r.aux = 6'(w[15:12]);
            r.sub_op = {2'b00, w[30], w[10]}; r.flags[F_64] = sf;
            r.cls = CLS_CSEL;
        end else if ((w & 32'h3a000000) == 32'h28000000) begin
            if (!(w[24:23] == 0 || (w[31:30] != 0 && w[31:30] != 2))) begin
                sc = (w[31:30] == 2) ? 3 : 2;
                r.rd = rd; r.rn = rn; r.rx = w[14:10];
                r.flags[F_LOAD] = w[22];
                r.sizes = {sc[1:0], sc[1:0]};
                r.imm = sign_ext(64'(w[21:15]), 7) << sc;
                r.mode = (w[24:23] == 1) ? M_POST : (w[24:23] == 2) ? M_OFF : M_PRE;
                r.cls = CLS_LSPAIR;
            end
        end else if ((w & 32'h3b000000) == 32'h39000000) begin
            if (mem_variant(w[31:30], w[23:22], r)) begin
                r.rd = rd; r.rn = rn; r.imm = 64'(w[21:10]) << w[31:30]; r.mode = M_OFF;
                r.cls = CLS_LSUIMM;
            end
        end else if ((w & 32'h3b200000) == 32'h38000000) begin
            if (w[11:10] != 2 && mem_variant(w[31:30], w[23:22], r)) begin
                r.rd = rd; r.rn = rn; r.imm = sign_ext(64'(w[20:12]), 9);
                r.mode = (w[11:10] == 0) ? M_OFF : (w[11:10] == 1) ? M_POST : M_PRE;
                r.cls = CLS_LSSIMM;
            end
        end else if ((w & 32'h3b200c00) == 32'h38200800) begin
            if (w[14] && mem_variant(w[31:30], w[23:22], r)) begin
                r.rd = rd; r.rn = rn; r.rm = rm; r.aux = 6'(w[15:13]);
                r.amount = 6'(w[12]);
                r.mode = M_OFF;
                r.cls = CLS_LSREG;
            end
        end else if ((w & 32'h1f000000) == 32'h0a000000) begin
            if (!(!sf && w[15])) begin
                r.rd = rd; r.rn = rn; r.rm = rm; r.mode = w[23:22]; r.amount = w[15:10];
                r.sub_op = (w[30:29] == 3) ? 4'd0 : 4'(w[30:29]);
                r.flags[F_64] = sf; r.flags[F_INV] = w[21]; r.flags[F_SET] = (w[30:29] == 3);
                r.cls = CLS_LOGSR;
            end
        end else if ((w & 32'h1f800000) == 32'h12000000) begin
            if (expand_mask(sf, w[22], w[21:16], w[15:10], m)) begin
                r.rd = rd; r.rn = rn; r.imm = m;
                r.sub_op = (w[30:29] == 3) ? 4'd0 : 4'(w[30:29]);
                r.flags[F_64] = sf; r.flags[F_SET] = (w[30:29] == 3);
                r.cls = CLS_LOGI;
            end
        end else if ((w & 32'h1f800000) == 32'h13000000) begin
            if (w[30:29] != 3 && !(!sf && (w[22] || w[21] || w[15])) && !(sf && !w[22])) begin
                r.rd = rd; r.rn = rn; r.amount = w[21:16]; r.aux = w[15:10];
                r.sub_op = 4'(w[30:29]); r.flags[F_64] = sf;
                r.cls = CLS_BFM;
            end
        end else if ((w & 32'h7f800000) == 32'h13800000) begin
            if (w[22] == sf && !(!sf && w[15])) begin
                r.rd = rd; r.rn = rn; r.rm = rm; r.amount = w[15:10]; r.flags[F_64] = sf;
                r.cls = CLS_EXTR;
            end
        end else if ((w & 32'h5fe00000) == 32'h5ac00000) begin
            if (w[15:10] == 4) begin
                r.rd = rd; r.rn = rn; r.flags[F_64] = sf;
                r.cls = CLS_DP1;
            end
        end else if ((w & 32'h7fe00000) == 32'h1ac00000) begin
            if (w[15:10] inside {2, 3, 8, 9, 10, 11}) begin
                r.sub_op = (w[15:10] <= 3) ? 4'(w[15:10] - 6'd2) : 4'(w[15:10] - 6'd6);
                r.rd = rd; r.rn = rn; r.rm = rm; r.flags[F_64] = sf;
                r.cls = CLS_DP2;
            end
        end else if ((w & 32'h7f000000) == 32'h1b000000) begin
            op = -1;
            if (w[23:21] == 0) op = int'(w[15]);
            else if (w[23:21] == 1 && sf) op = 2 + int'(w[15]);
            else if (w[23:21] == 2 && sf && !w[15] && w[14:10] == 31) op = 4;
            else if (w[23:21] == 5 && sf) op = 5 + int'(w[15]);
            else if (w[23:21] == 6 && sf && !w[15] && w[14:10] == 31) op = 7;
            if (op >= 0) begin
                r.sub_op = 4'(op); r.rd = rd; r.rn = rn; r.rx = w[14:10]; r.rm = rm;
                r.flags[F_64] = sf;
                r.cls = CLS_MUL;
            end
        end else if ((w & 32'h1f800000) == 32'h12800000) begin
            if (w[30:29] != 1 && !(!sf && w[22])) begin
                r.rd = rd; r.imm = 64'(w[20:5]); r.amount = {w[22:21], 4'd0};
                r.sub_op = (w[30:29] == 0) ? 4'd0 : (w[30:29] == 2) ? 4'd1 : 4'd2;
                r.flags[F_64] = sf;
                r.cls = CLS_MOVW;
            end
        end else if (w == 32'hd5033f5f) begin
            r.cls = CLS_CLREX;
        end else if ((w & 32'h3f007c00) == 32'h08007c00) begin
            if (!((!w[22] && w[23] && rm != 31) || (w[22] && rm != 31))) begin
                r.rd = rd; r.rn = rn; r.rx = rm; r.sizes = {w[31:30], w[31:30]};
                r.flags[F_LOAD] = w[22]; r.flags[F_EXCL] = !w[23];
                r.flags[F_ACQ] = w[22] && w[15]; r.flags[F_REL] = !w[22] && w[15];
                r.cls = CLS_LSEX;
            end
        end else if ((w & 32'hfff00000) == 32'hd5300000 ||
                     (w & 32'hfff00000) == 32'hd5100000) begin
            sr = w[20:5];
            if (sr == 16'hde82 || sr == 16'hda10) begin
                r.rd = rd; r.sub_op = (sr == 16'hde82) ? 4'd0 : 4'd1;
                r.flags[F_SYSW] = ((w & 32'hfff00000) == 32'hd5100000);
                r.cls = CLS_SYSREG;
            end
        end
        if (r.cls == CLS_UNSUP) begin
            r = '0;
        end
        return r;
    endfunction

    function automatic logic [31:0] shaped_word();
        int k;
        if ($urandom_range(0, 9) == 0) begin
            return $urandom();
        end
        k = $urandom_range(0, tmpl_val.size() - 1);
        return (tmpl_val[k] & ~tmpl_msk[k]) | ($urandom() & tmpl_msk[k]);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    // Driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                decoded_queue.push_back(decode_word(i_instruction_word));
                words_sent++;
            end
            if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (hold_until_drained && (decoded_queue.size() != 0 || i_valid)) begin
                i_valid <= 1'b0;
            end else if (word_queue.size() != 0) begin
                if (hold_until_drained) hold_until_drained = 1'b0;
                i_valid <= 1'b1;
                i_instruction_word <= word_queue.pop_front();
                if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(1, 11);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor and result check.
    always @(posedge i_clk) begin
        t_record exp_rec;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (decoded_queue.size() == 0) begin
                    $error("result with no instruction pending");
                    error_count++;
                end else begin
                    exp_rec = decoded_queue.pop_front();
                    records_seen++;
                    class_hits[exp_rec.cls]++;
                    if (o_instr_class !== exp_rec.cls) begin
                        $error("instr_class exp %0d got %0d", exp_rec.cls, o_instr_class);
                        error_count++;
                    end
                    if (o_dest_reg !== exp_rec.rd) begin
                        $error("dest_reg exp %0d got %0d", exp_rec.rd, o_dest_reg);
                        error_count++;
                    end
                    if (o_src_reg_a !== exp_rec.rn) begin
                        $error("src_reg_a exp %0d got %0d", exp_rec.rn, o_src_reg_a);
                        error_count++;
                    end
                    if (o_src_reg_b !== exp_rec.rm) begin
                        $error("src_reg_b exp %0d got %0d", exp_rec.rm, o_src_reg_b);
                        error_count++;
                    end
                    if (o_extra_reg !== exp_rec.rx) begin
                        $error("extra_reg exp %0d got %0d", exp_rec.rx, o_extra_reg);
                        error_count++;
                    end
                    if (o_immediate !== exp_rec.imm) begin
                        $error("immediate exp %h got %h", exp_rec.imm, o_immediate);
                        error_count++;
                    end
                    if (o_sub_op !== exp_rec.sub_op) begin
                        $error("sub_op exp %0d got %0d", exp_rec.sub_op, o_sub_op);
                        error_count++;
                    end
                    if (o_amount !== exp_rec.amount) begin
                        $error("amount exp %0d got %0d", exp_rec.amount, o_amount);
                        error_count++;
                    end
                    if (o_aux_field !== exp_rec.aux) begin
                        $error("aux_field exp %0d got %0d", exp_rec.aux, o_aux_field);
                        error_count++;
                    end
                    if (o_mode !== exp_rec.mode) begin
                        $error("mode exp %0d got %0d", exp_rec.mode, o_mode);
                        error_count++;
                    end
                    if (o_flags !== exp_rec.flags) begin
                        $error("flags exp %h got %h", exp_rec.flags, o_flags);
                        error_count++;
                    end
                    if (o_sizes !== exp_rec.sizes) begin
                        $error("sizes exp %h got %h", exp_rec.sizes, o_sizes);
                        error_count++;
                    end
                end
            end
            if (take_gap > 0) begin
                take_gap--;
                i_ready <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 6) == 0) begin
                take_gap = $urandom_range(0, 10);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        int covered;
        error_count = 0;
        words_sent = 0;
        records_seen = 0;
        hold_until_drained = 1'b0;
        quiet_phase = 1'b0;
        send_gap = 0;
        take_gap = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_instruction_word = '0;
        foreach (class_hits[k]) class_hits[k] = 0;

        // Directed: all-zero and all-ones words, every class template, and reserved forms.
        word_queue.push_back(32'h00000000);
        word_queue.push_back(32'hffffffff);
        foreach (tmpl_val[k]) word_queue.push_back(tmpl_val[k]);
        word_queue.push_back(32'h90ffffe0);   // page address, negative offset
        word_queue.push_back(32'h11c00000);   // add immediate with reserved shift
        word_queue.push_back(32'h92400000);   // logical immediate, 64-bit element with one bit set
        word_queue.push_back(32'h38200800);   // register offset with reserved extend

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == NUM_RANDOM / 2) begin
                while (word_queue.size() != 0) @(posedge i_clk);
                hold_until_drained = 1'b1;
            end
            if (n == NUM_RANDOM - 100) begin
                quiet_phase = 1'b1;
            end
            word_queue.push_back(shaped_word());
        end

        while (word_queue.size() != 0 || i_valid) @(posedge i_clk);
        while (decoded_queue.size() != 0) @(posedge i_clk);
        repeat (QUIET_TAIL) @(posedge i_clk);

        covered = 0;
        foreach (class_hits[k]) if (class_hits[k] != 0) covered++;
        $display("Sent %0d instruction words and checked %0d records under random stalls.",
                 words_sent, records_seen);
        $display("Instruction classes seen, unsupported included: %0d of 29.", covered);
        if (error_count == 0 && decoded_queue.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
